@@ hdl/gcft_pkg.sv @@
// package for the greedy column fill tree core
package gcft_pkg;
  localparam int unsigned NumColumnsDefault = 1024;
  localparam int unsigned CountBitsDefault  = 16;
  localparam int unsigned FieldBits         = 11;
  localparam int unsigned CostBits          = 63;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SPAN,
    ST_FILL,
    ST_COST,
    ST_DONE
  } state_t;
endpackage

@@ hdl/gcft_ram.sv @@
// generic single port ram with registered read
module gcft_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hdl/greedy_column_fill_tree_core.sv @@
// top level of the greedy column fill tree core
//
//  channel | signals                                        | dir
//  request | req_valid req_ready mast_height unit_count last_mast | in
//  result  | rsp_valid rsp_ready total_cost cost_saturated final_result | out
//
// sequence: a request with h and k nonzero, once taken, reads the count at
//   column h-k+1, then takes a read and an update slot per column 1..h, one write
//   per filled column, a step for the cost and a step for the result;
//   an empty request goes straight to the result step
// reset: a clearing pass zeroes the column memory, and the same pass runs after
//   every request marked last
// stalls: the result sits in an output register; a held result blocks the next
//   request until it is taken
module greedy_column_fill_tree_core
  import gcft_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = NumColumnsDefault,
  parameter int unsigned COUNT_BITS  = CountBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [FieldBits-1:0]  mast_height,
  input  logic [FieldBits-1:0]  unit_count,
  input  logic                  last_mast,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [CostBits-1:0]   total_cost,
  output logic                  cost_saturated,
  output logic                  final_result
);
  localparam int unsigned AW = $clog2(NUM_COLUMNS);
  localparam int unsigned CW = $clog2(NUM_COLUMNS + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [CostBits-1:0] CostLimit = '1;

  state_t state, state_next;

  logic [CW-1:0] h, k, col, p2, p1, x_col, rem;
  logic          last, have_p1, pend;
  logic [COUNT_BITS-1:0] x;
  logic [CostBits-1:0]   cost;
  logic [CostBits:0]     add;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  gcft_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_COLUMNS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [CW-1:0] h_in, k_in;

  always_comb begin
    h_in = (32'(mast_height) > NUM_COLUMNS) ? CW'(NUM_COLUMNS) : CW'(mast_height);
    k_in = (32'(unit_count) > 32'(h_in)) ? h_in : CW'(unit_count);
  end

  assign req_ready = (state == ST_IDLE) && !rsp_valid;

  // span scan: pend high means ram_rdata holds the count of column col
  logic          at_least, at_most;
  logic [CW-1:0] p2_now, p1_now;
  assign at_least = ram_rdata >= x;
  assign at_most  = ram_rdata <= x;
  assign p2_now   = at_least ? col : p2;
  assign p1_now   = (!have_p1 && at_most) ? col : p1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (col == CW'(NUM_COLUMNS)) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid && req_ready) begin
        state_next = (h_in == '0 || k_in == '0) ? ST_DONE : ST_LOOKUP;
      end
      ST_LOOKUP: if (pend) state_next = ST_SPAN;
      ST_SPAN:   if (pend && col == h) state_next = ST_FILL;
      ST_FILL:   if (rem == CW'(1)) state_next = ST_COST;
      ST_COST:   state_next = ST_DONE;
      ST_DONE:   if (!rsp_valid) state_next = last ? ST_CLEAR : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(col - CW'(1));
    ram_wdata = ram_rdata + COUNT_BITS'(1);
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_LOOKUP: if (!pend) ram_addr = AW'(x_col - CW'(1));
      ST_SPAN:   if (pend && !at_least) ram_we = 1'b1;
      ST_FILL: begin
        ram_wdata = x + COUNT_BITS'(1);
        if (x != CountMax) ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  // span: p2 is the last column with count >= x; columns after it up to h rise
  // fill: r units from the first column with count <= x, all of them at count x
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      col       <= CW'(1);
      rsp_valid <= 1'b0;
      cost      <= '0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          col  <= col + CW'(1);
          cost <= '0;
        end
        ST_IDLE: if (req_valid && req_ready) begin
          h     <= h_in;
          k     <= k_in;
          last  <= last_mast;
          x_col <= h_in - k_in + CW'(1);
          pend  <= 1'b0;
          add   <= '0;
        end
        ST_LOOKUP: begin
          if (!pend) begin
            pend <= 1'b1;
          end else begin
            x       <= ram_rdata;
            col     <= CW'(1);
            p2      <= '0;
            p1      <= '0;
            have_p1 <= 1'b0;
            pend    <= 1'b0;
          end
        end
        ST_SPAN: begin
          if (!pend) begin
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (at_least) p2 <= col;
            if (!have_p1 && at_most) begin
              have_p1 <= 1'b1;
              p1      <= col;
            end
            if (!at_least) add <= add + (CostBits+1)'(ram_rdata);
            if (col == h) begin
              col <= p1_now;
              rem <= k - (h - p2_now);
            end else begin
              col <= col + CW'(1);
            end
          end
        end
        ST_FILL: begin
          col <= col + CW'(1);
          rem <= rem - CW'(1);
          add <= add + (CostBits+1)'(x);
        end
        ST_COST: begin
          if ({1'b0, cost} + add > {1'b0, CostLimit}) cost <= CostLimit;
          else cost <= cost + add[CostBits-1:0];
        end
        ST_DONE: begin
          if (!rsp_valid) begin
            rsp_valid      <= 1'b1;
            total_cost     <= cost;
            cost_saturated <= (cost == CostLimit);
            final_result   <= last;
            if (last) col <= CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) req_valid && req_ready |-> !rsp_valid)
    else $error("request taken while result held");
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_cost))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) ram_we |-> state != ST_IDLE)
    else $error("write while idle");
endmodule
